// ----- hw/rtl/rv32_subset_cpu_step_core_macros.svh -----
// Assertion macros used by the core's controller.
`ifndef RV32_SUBSET_CPU_STEP_CORE_MACROS_SVH
`define RV32_SUBSET_CPU_STEP_CORE_MACROS_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define RVSC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rvsc assertion failed");

// Next-cycle implication, checked on clk and disabled in reset.
`define RVSC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rvsc assertion failed");

`endif

// ----- hw/rtl/rvsc_pkg.sv -----
// Package: types, codes and controller/datapath interface of the rv32 subset core.
package rvsc_pkg;

  localparam int MEM_WORDS_DEF = 16384;

  // item actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_EXEC  = 2'd1;
  localparam logic [1:0] ACT_RDMEM = 2'd2;
  localparam logic [1:0] ACT_RDREG = 2'd3;

  // decoded instruction kinds
  localparam logic [3:0] K_OTHER  = 4'd0;
  localparam logic [3:0] K_LUI    = 4'd1;
  localparam logic [3:0] K_ADD    = 4'd2;
  localparam logic [3:0] K_ADDI   = 4'd3;
  localparam logic [3:0] K_LW     = 4'd4;
  localparam logic [3:0] K_LBU    = 4'd5;
  localparam logic [3:0] K_SW     = 4'd6;
  localparam logic [3:0] K_SB     = 4'd7;
  localparam logic [3:0] K_JALR   = 4'd8;
  localparam logic [3:0] K_EBREAK = 4'd9;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [31:0] data;
  } req_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        halted;
    logic [31:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic take;      // latch the accepted item
    logic clr_wr;    // clear one memory word
    logic item_wr;   // load-word action write
    logic item_rd;   // read-memory action
    logic reg_rd;    // read-register action
    logic fetch;     // read instruction at pc
    logic decode;    // latch instruction, read rs1/rs2
    logic exec;      // retire instructions other than LW/LBU/SB
    logic data_rd;   // data read for LW/LBU/SB
    logic finish;    // retire LW/LBU/SB
    logic out_load;  // capture result item
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       halted;
    logic [3:0] kind;
  } dp_status_t;

endpackage

// ----- hw/rtl/rvsc_datapath.sv -----
// Datapath: pc, halt flag, register file, word memory and result register.
module rvsc_datapath #(
  parameter int MEM_WORDS = rvsc_pkg::MEM_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rvsc_pkg::req_t      request,
  input  rvsc_pkg::dp_cmd_t   cmd,
  output rvsc_pkg::dp_status_t st,
  output rvsc_pkg::rsp_t      response
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [29:0] MEM_LIMIT = 30'(MEM_WORDS);

  logic [31:0]   pc;
  logic          halt;
  rvsc_pkg::req_t item;
  logic [31:0]   ir;
  logic [AW-1:0] clr_cnt;
  rvsc_pkg::rsp_t rsp_q;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] memq;
  logic        memq_ok;

  logic [31:0] rf [16];
  logic [15:0] rf_valid;
  logic [31:0] rfq_a, rfq_b;
  logic        rfv_a, rfv_b;

  logic [31:0] inst_w, word_q, a, b, imm_i, imm_s, imm_u, ea, pc4, merged, byte_q;
  logic [3:0]  kind, rd, rs1, rs2;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        pc_ok, item_ok, ea_ok;

  logic          mem_we, mem_re, ra_ok;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;

  logic        rf_we, rf_re;
  logic [3:0]  rf_wa, rf_ra_a, rf_ra_b;
  logic [31:0] rf_wd;

  assign inst_w = memq_ok ? memq : 32'd0;
  assign word_q = memq_ok ? memq : 32'd0;
  assign a      = rfv_a ? rfq_a : 32'd0;
  assign b      = rfv_b ? rfq_b : 32'd0;

  assign opc = ir[6:0];
  assign f3  = ir[14:12];
  assign f7  = ir[31:25];
  assign rd  = ir[10:7];
  assign rs1 = inst_w[18:15];
  assign rs2 = inst_w[23:20];

  assign imm_i = {{20{ir[31]}}, ir[31:20]};
  assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_u = {ir[31:12], 12'd0};
  assign pc4   = pc + 32'd4;
  assign ea    = a + (((kind == rvsc_pkg::K_SW) || (kind == rvsc_pkg::K_SB)) ? imm_s : imm_i);

  assign pc_ok   = pc[31:2] < MEM_LIMIT;
  assign item_ok = item.address[31:2] < MEM_LIMIT;
  assign ea_ok   = ea[31:2] < MEM_LIMIT;

  always_comb begin
    kind = rvsc_pkg::K_OTHER;
    if (ir == rvsc_pkg::INSN_EBREAK) begin
      kind = rvsc_pkg::K_EBREAK;
    end else begin
      case (opc)
        rvsc_pkg::OP_LUI:   kind = rvsc_pkg::K_LUI;
        rvsc_pkg::OP_REG:   if (f3 == 3'd0 && f7 == 7'd0) kind = rvsc_pkg::K_ADD;
        rvsc_pkg::OP_IMM:   if (f3 == 3'd0) kind = rvsc_pkg::K_ADDI;
        rvsc_pkg::OP_LOAD: begin
          if (f3 == 3'd2) kind = rvsc_pkg::K_LW;
          else if (f3 == 3'd4) kind = rvsc_pkg::K_LBU;
        end
        rvsc_pkg::OP_STORE: begin
          if (f3 == 3'd2) kind = rvsc_pkg::K_SW;
          else if (f3 == 3'd0) kind = rvsc_pkg::K_SB;
        end
        rvsc_pkg::OP_JALR:  if (f3 == 3'd0) kind = rvsc_pkg::K_JALR;
        default:            kind = rvsc_pkg::K_OTHER;
      endcase
    end
  end

  // little-endian byte lanes
  always_comb begin
    merged = word_q;
    case (ea[1:0])
      2'd0: begin byte_q = {24'd0, word_q[7:0]};   merged[7:0]   = b[7:0]; end
      2'd1: begin byte_q = {24'd0, word_q[15:8]};  merged[15:8]  = b[7:0]; end
      2'd2: begin byte_q = {24'd0, word_q[23:16]}; merged[23:16] = b[7:0]; end
      default: begin byte_q = {24'd0, word_q[31:24]}; merged[31:24] = b[7:0]; end
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = 32'd0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
    end else if (cmd.item_wr) begin
      mem_we = item_ok;
      mem_wa = item.address[AW+1:2];
      mem_wd = item.data;
    end else if (cmd.exec && kind == rvsc_pkg::K_SW) begin
      mem_we = ea_ok;
      mem_wa = ea[AW+1:2];
      mem_wd = b;
    end else if (cmd.finish && kind == rvsc_pkg::K_SB) begin
      mem_we = ea_ok;
      mem_wa = ea[AW+1:2];
      mem_wd = merged;
    end
  end

  always_comb begin
    mem_re = cmd.fetch | cmd.item_rd | cmd.data_rd;
    mem_ra = pc[AW+1:2];
    ra_ok  = pc_ok;
    if (cmd.item_rd) begin
      mem_ra = item.address[AW+1:2];
      ra_ok  = item_ok;
    end else if (cmd.data_rd) begin
      mem_ra = ea[AW+1:2];
      ra_ok  = ea_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      memq    <= mem[mem_ra];
      memq_ok <= ra_ok;
    end
  end

  // register file; x0 is never written, so it always reads zero
  always_comb begin
    rf_we = 1'b0;
    rf_wd = 32'd0;
    if (cmd.exec) begin
      case (kind)
        rvsc_pkg::K_LUI:  begin rf_we = 1'b1; rf_wd = imm_u; end
        rvsc_pkg::K_ADD:  begin rf_we = 1'b1; rf_wd = a + b; end
        rvsc_pkg::K_ADDI: begin rf_we = 1'b1; rf_wd = ea; end
        rvsc_pkg::K_JALR: begin rf_we = 1'b1; rf_wd = pc4; end
        default:          rf_we = 1'b0;
      endcase
    end else if (cmd.finish) begin
      case (kind)
        rvsc_pkg::K_LW:  begin rf_we = 1'b1; rf_wd = word_q; end
        rvsc_pkg::K_LBU: begin rf_we = 1'b1; rf_wd = byte_q; end
        default:         rf_we = 1'b0;
      endcase
    end
    rf_we   = rf_we && (rd != 4'd0);
    rf_wa   = rd;
    rf_re   = cmd.decode | cmd.reg_rd;
    rf_ra_a = cmd.reg_rd ? item.address[3:0] : rs1;
    rf_ra_b = rs2;
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (rf_re) begin
      rfq_a <= rf[rf_ra_a];
      rfq_b <= rf[rf_ra_b];
      rfv_a <= rf_valid[rf_ra_a];
      rfv_b <= rf_valid[rf_ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= 16'd0;
      pc       <= 32'd0;
      halt     <= 1'b0;
      clr_cnt  <= '0;
    end else begin
      if (rf_we) rf_valid[rf_wa] <= 1'b1;
      if (cmd.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.exec) begin
        case (kind)
          rvsc_pkg::K_EBREAK: halt <= 1'b1;
          rvsc_pkg::K_JALR:   pc   <= ea & 32'hFFFF_FFFE;
          default:            pc   <= pc4;
        endcase
      end else if (cmd.finish) begin
        pc <= pc4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) item <= request;
    if (cmd.decode) ir <= inst_w;
    if (cmd.out_load) begin
      rsp_q.pc     <= pc;
      rsp_q.halted <= halt;
      case (item.action)
        rvsc_pkg::ACT_RDMEM: rsp_q.read_data <= word_q;
        rvsc_pkg::ACT_RDREG: rsp_q.read_data <= a;
        default:             rsp_q.read_data <= 32'd0;
      endcase
    end
  end

  assign response    = rsp_q;
  assign st.clr_done = clr_cnt == AW'(MEM_WORDS - 1);
  assign st.halted   = halt;
  assign st.kind     = kind;

endmodule

// ----- hw/rtl/rvsc_controller.sv -----
// Controller: sequences memory clear, actions and instruction steps; owns the handshakes.
`include "rv32_subset_cpu_step_core_macros.svh"

module rvsc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  output logic                 request_stall,
  input  logic [1:0]           action,
  output logic                 response_valid,
  input  logic                 response_stall,
  input  rvsc_pkg::dp_status_t st,
  output rvsc_pkg::dp_cmd_t    cmd
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LOADW  = 4'd2;
  localparam logic [3:0] ST_RDMEM  = 4'd3;
  localparam logic [3:0] ST_RDREG  = 4'd4;
  localparam logic [3:0] ST_FETCH  = 4'd5;
  localparam logic [3:0] ST_DECODE = 4'd6;
  localparam logic [3:0] ST_EXEC   = 4'd7;
  localparam logic [3:0] ST_MEMRD  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state, state_next;
  logic       out_valid;
  logic       accept;

  assign request_stall  = state != ST_IDLE;
  assign accept         = request_valid && !request_stall;
  assign response_valid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          case (action)
            rvsc_pkg::ACT_LOAD:  state_next = ST_LOADW;
            rvsc_pkg::ACT_EXEC:  state_next = st.halted ? ST_DONE : ST_FETCH;
            rvsc_pkg::ACT_RDMEM: state_next = ST_RDMEM;
            default:             state_next = ST_RDREG;
          endcase
        end
      end
      ST_LOADW: begin
        cmd.item_wr = 1'b1;
        state_next  = ST_DONE;
      end
      ST_RDMEM: begin
        cmd.item_rd = 1'b1;
        state_next  = ST_DONE;
      end
      ST_RDREG: begin
        cmd.reg_rd = 1'b1;
        state_next = ST_DONE;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (st.kind == rvsc_pkg::K_LW || st.kind == rvsc_pkg::K_LBU ||
            st.kind == rvsc_pkg::K_SB) begin
          cmd.data_rd = 1'b1;
          state_next  = ST_MEMRD;
        end else begin
          cmd.exec   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_MEMRD: begin
        cmd.finish = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid || !response_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!response_stall) out_valid <= 1'b0;
    end
  end

  `RVSC_ASSERT_NEXT(a_accept_busy, accept, state != ST_IDLE)
  `RVSC_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || !response_stall)
  `RVSC_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state) == ST_DONE)
  `RVSC_ASSERT_NEXT(a_halt_sticky, st.halted, st.halted)

endmodule

// ----- hw/rtl/rv32_subset_cpu_step_core.sv -----
// Top level of the rv32 subset core: controller plus datapath.
//
//  channel   | valid           | stall           | payload
//  ----------+-----------------+-----------------+-------------------------------
//  request   | request_valid   | request_stall   | request  (action, address, data)
//  response  | response_valid  | response_stall  | response (pc, halted, read_data)
//
// After reset the memory is cleared one word a cycle while request_stall stays high.
// Load word, read memory and read register items go from their action state to the result.
// An execute item steps through fetch, decode with register read, execute, a data read for LW,
// LBU and SB only, and result; a halted core goes straight to the result.
// One item is in work at a time; a result waiting under response_stall blocks only the next one.
module rv32_subset_cpu_step_core #(
  parameter int MEM_WORDS = rvsc_pkg::MEM_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  output logic           request_stall,
  input  rvsc_pkg::req_t request,
  output logic           response_valid,
  input  logic           response_stall,
  output rvsc_pkg::rsp_t response
);

  rvsc_pkg::dp_cmd_t    cmd;
  rvsc_pkg::dp_status_t st;

  rvsc_controller u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .request_valid  (request_valid),
    .request_stall  (request_stall),
    .action         (request.action),
    .response_valid (response_valid),
    .response_stall (response_stall),
    .st             (st),
    .cmd            (cmd)
  );

  rvsc_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .st       (st),
    .response (response)
  );

endmodule
